@@ design/servo_state_observer_assert.svh @@
// Assertion macros shared by the servo state observer RTL.
// Included by bare file name; no other dependencies.
`ifndef SERVO_STATE_OBSERVER_ASSERT_SVH
`define SERVO_STATE_OBSERVER_ASSERT_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define SSO_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("servo_state_observer: assertion failed");

// Antecedent holds -> consequent holds in the next cycle.
`define SSO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("servo_state_observer: assertion failed");

`endif

@@ design/sso_pkg.sv @@
// Package for the servo state observer: widths, codes and payload types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sso_pkg;

   localparam int DATA_WIDTH     = 32;
   localparam int COEF_WIDTH     = 32;
   localparam int COEF_FRAC_BITS = 24;

   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_INDEX_WIDTH = 3;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_POSITION    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_VELOCITY    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_DISTURBANCE = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_A_POS_VEL        = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_A_VEL_VEL        = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_B_POS            = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_B_VEL            = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_APPROX_MODE      = 3'd7;

   // request kinds
   localparam logic [1:0] REQ_CORRECT = 2'd0;
   localparam logic [1:0] REQ_PREDICT = 2'd1;
   localparam logic [1:0] REQ_LOAD    = 2'd2;

   typedef struct packed {
      logic [1:0]                   req_type;
      logic signed [DATA_WIDTH-1:0] measured_position;
      logic signed [DATA_WIDTH-1:0] control_input;
      logic signed [DATA_WIDTH-1:0] init_position;
      logic signed [DATA_WIDTH-1:0] init_velocity;
      logic signed [DATA_WIDTH-1:0] init_disturbance;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] position_estimate;
      logic signed [DATA_WIDTH-1:0] velocity_estimate;
      logic signed [DATA_WIDTH-1:0] disturbance_estimate;
      logic                         saturated;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] position;
      logic signed [DATA_WIDTH-1:0] velocity;
      logic signed [DATA_WIDTH-1:0] disturbance;
   } est_type;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] gain_position;
      logic signed [COEF_WIDTH-1:0] gain_velocity;
      logic signed [COEF_WIDTH-1:0] gain_disturbance;
      logic signed [COEF_WIDTH-1:0] a_pos_vel;
      logic signed [COEF_WIDTH-1:0] a_vel_vel;
      logic signed [COEF_WIDTH-1:0] b_pos;
      logic signed [COEF_WIDTH-1:0] b_vel;
      logic                         approx_mode;
   } cfg_type;

endpackage

@@ design/sso_csr.sv @@
// Configuration register file of the servo state observer, APB-style access.
// Depends on sso_pkg for register indexes and the cfg_type bundle.
`timescale 1ns / 1ps

module sso_csr
   import sso_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output cfg_type                   cfg
);

   cfg_type                    cfg_ff;
   cfg_type                    cfg_in;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic                       write_en;

   assign index    = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign write_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_GAIN_POSITION:    cfg_in.gain_position    = COEF_WIDTH'(csr_pwdata);
            REG_GAIN_VELOCITY:    cfg_in.gain_velocity    = COEF_WIDTH'(csr_pwdata);
            REG_GAIN_DISTURBANCE: cfg_in.gain_disturbance = COEF_WIDTH'(csr_pwdata);
            REG_A_POS_VEL:        cfg_in.a_pos_vel        = COEF_WIDTH'(csr_pwdata);
            REG_A_VEL_VEL:        cfg_in.a_vel_vel        = COEF_WIDTH'(csr_pwdata);
            REG_B_POS:            cfg_in.b_pos            = COEF_WIDTH'(csr_pwdata);
            REG_B_VEL:            cfg_in.b_vel            = COEF_WIDTH'(csr_pwdata);
            REG_APPROX_MODE:      cfg_in.approx_mode      = csr_pwdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         REG_GAIN_POSITION:    csr_prdata = CSR_DATA_WIDTH'(cfg_ff.gain_position);
         REG_GAIN_VELOCITY:    csr_prdata = CSR_DATA_WIDTH'(cfg_ff.gain_velocity);
         REG_GAIN_DISTURBANCE: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.gain_disturbance);
         REG_A_POS_VEL:        csr_prdata = CSR_DATA_WIDTH'(cfg_ff.a_pos_vel);
         REG_A_VEL_VEL:        csr_prdata = CSR_DATA_WIDTH'(cfg_ff.a_vel_vel);
         REG_B_POS:            csr_prdata = CSR_DATA_WIDTH'(cfg_ff.b_pos);
         REG_B_VEL:            csr_prdata = CSR_DATA_WIDTH'(cfg_ff.b_vel);
         REG_APPROX_MODE:      csr_prdata = CSR_DATA_WIDTH'(cfg_ff.approx_mode);
         default:              csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

@@ design/sso_datapath.sv @@
// Single-pass estimate update: operand select, four scaled multipliers, saturating sums.
// Depends on sso_pkg for payload, estimate and configuration types.
`timescale 1ns / 1ps

module sso_datapath
   import sso_pkg::*;
(
   input  req_payload_type item,
   input  est_type         est,
   input  cfg_type         cfg,
   output rsp_payload_type result
);

   localparam int ERR_WIDTH   = DATA_WIDTH + 1;
   localparam int PROD_WIDTH  = COEF_WIDTH + ERR_WIDTH;
   localparam int MAG_WIDTH   = PROD_WIDTH + 1 - COEF_FRAC_BITS;
   localparam int TERM_WIDTH  = 62;
   localparam int CMP_WIDTH   = (MAG_WIDTH > TERM_WIDTH) ? MAG_WIDTH : TERM_WIDTH;
   localparam int SUM_WIDTH   = 64;
   localparam int LIMIT_LOG2  = 60;

   localparam logic [PROD_WIDTH:0] ROUND_BIAS =
      (PROD_WIDTH + 1)'(64'd1 << (COEF_FRAC_BITS - 1));
   localparam logic [CMP_WIDTH-1:0] PRODUCT_LIMIT = CMP_WIDTH'(64'd1 << LIMIT_LOG2);
   localparam logic signed [SUM_WIDTH-1:0] SAT_HI =
      SUM_WIDTH'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
   localparam logic signed [SUM_WIDTH-1:0] SAT_LO = -SAT_HI - SUM_WIDTH'(1);

   typedef struct packed {
      logic                         clipped;
      logic signed [DATA_WIDTH-1:0] value;
   } sat_type;

   // coef * x >> frac bits, rounded half away from zero, magnitude clamped
   function automatic logic signed [TERM_WIDTH-1:0] scale_product(
      input logic signed [COEF_WIDTH-1:0] c,
      input logic signed [ERR_WIDTH-1:0]  x
   );
      logic [COEF_WIDTH-1:0] c_mag;
      logic [ERR_WIDTH-1:0]  x_mag;
      logic [PROD_WIDTH-1:0] prod;
      logic [PROD_WIDTH:0]   rounded;
      logic [CMP_WIDTH-1:0]  mag;
      logic [TERM_WIDTH-1:0] lim;
      c_mag   = c[COEF_WIDTH-1] ? COEF_WIDTH'(-c) : COEF_WIDTH'(c);
      x_mag   = x[ERR_WIDTH-1] ? ERR_WIDTH'(-x) : ERR_WIDTH'(x);
      prod    = PROD_WIDTH'(c_mag) * PROD_WIDTH'(x_mag);
      rounded = {1'b0, prod} + ROUND_BIAS;
      mag     = CMP_WIDTH'(rounded[PROD_WIDTH:COEF_FRAC_BITS]);
      if (mag > PRODUCT_LIMIT) begin
         mag = PRODUCT_LIMIT;
      end
      lim = TERM_WIDTH'(mag);
      if (c[COEF_WIDTH-1] != x[ERR_WIDTH-1]) begin
         return -signed'(lim);
      end
      return signed'(lim);
   endfunction

   function automatic sat_type saturate(input logic signed [SUM_WIDTH-1:0] s);
      sat_type r;
      if (s > SAT_HI) begin
         r.clipped = 1'b1;
         r.value   = DATA_WIDTH'(SAT_HI);
      end else if (s < SAT_LO) begin
         r.clipped = 1'b1;
         r.value   = DATA_WIDTH'(SAT_LO);
      end else begin
         r.clipped = 1'b0;
         r.value   = DATA_WIDTH'(s);
      end
      return r;
   endfunction

   logic signed [ERR_WIDTH-1:0]  err;
   logic signed [ERR_WIDTH-1:0]  vel_x;
   logic signed [ERR_WIDTH-1:0]  uc_x;
   sat_type                      uc_sat;
   logic signed [COEF_WIDTH-1:0] m0_c, m1_c, m2_c;
   logic signed [ERR_WIDTH-1:0]  m0_x, m1_x, m2_x;
   logic signed [TERM_WIDTH-1:0] m0, m1, m2, m3;
   logic signed [TERM_WIDTH-1:0] pp_extra;
   sat_type                      pos_c, vel_c, dist_c, pos_p, vel_p;
   logic                         is_predict;

   assign is_predict = (item.req_type == REQ_PREDICT);
   assign err    = ERR_WIDTH'(item.measured_position) - ERR_WIDTH'(est.position);
   assign uc_sat = saturate(SUM_WIDTH'(est.disturbance) + SUM_WIDTH'(item.control_input));
   assign vel_x  = ERR_WIDTH'(est.velocity);
   assign uc_x   = ERR_WIDTH'(uc_sat.value);

   // multipliers m0-m2 are shared between correct and predict; m3 is predict only
   always_comb begin
      if (is_predict) begin
         m0_c = cfg.a_pos_vel;  m0_x = vel_x;
         m1_c = cfg.b_pos;      m1_x = uc_x;
         m2_c = cfg.a_vel_vel;  m2_x = vel_x;
      end else begin
         m0_c = cfg.gain_velocity;     m0_x = err;
         m1_c = cfg.gain_position;     m1_x = err;
         m2_c = cfg.gain_disturbance;  m2_x = err;
      end
   end

   assign m0 = scale_product(m0_c, m0_x);
   assign m1 = scale_product(m1_c, m1_x);
   assign m2 = scale_product(m2_c, m2_x);
   assign m3 = scale_product(cfg.b_vel, uc_x);

   assign pp_extra = cfg.approx_mode ? '0 : m1;

   assign pos_c  = saturate(SUM_WIDTH'(est.position) + SUM_WIDTH'(m1));
   assign vel_c  = saturate(SUM_WIDTH'(est.velocity) + SUM_WIDTH'(m0));
   assign dist_c = saturate(SUM_WIDTH'(est.disturbance) + SUM_WIDTH'(m2));
   assign pos_p  = saturate(SUM_WIDTH'(est.position) + SUM_WIDTH'(m0)
                            + SUM_WIDTH'(pp_extra));
   assign vel_p  = saturate(SUM_WIDTH'(m2) + SUM_WIDTH'(m3));

   always_comb begin
      result.position_estimate    = est.position;
      result.velocity_estimate    = est.velocity;
      result.disturbance_estimate = est.disturbance;
      result.saturated            = 1'b0;
      case (item.req_type)
         REQ_CORRECT: begin
            result.velocity_estimate = vel_c.value;
            if (cfg.approx_mode) begin
               result.position_estimate = item.measured_position;
               result.saturated         = vel_c.clipped;
            end else begin
               result.position_estimate    = pos_c.value;
               result.disturbance_estimate = dist_c.value;
               result.saturated = pos_c.clipped | vel_c.clipped | dist_c.clipped;
            end
         end
         REQ_PREDICT: begin
            result.position_estimate = pos_p.value;
            if (cfg.approx_mode) begin
               result.saturated = pos_p.clipped;
            end else begin
               result.velocity_estimate = vel_p.value;
               result.saturated = uc_sat.clipped | pos_p.clipped | vel_p.clipped;
            end
         end
         REQ_LOAD: begin
            result.position_estimate    = item.init_position;
            result.velocity_estimate    = item.init_velocity;
            result.disturbance_estimate = item.init_disturbance;
         end
         default: begin
            result.saturated = 1'b0;
         end
      endcase
   end

endmodule

@@ design/servo_state_observer.sv @@
// Top level of the servo state observer: request register, estimate state, result register.
// Depends on sso_pkg, sso_csr, sso_datapath and servo_state_observer_assert.svh.
`timescale 1ns / 1ps

// Each request transaction (correct, predict or load) yields exactly one response
// transaction carrying the three Q16.16 estimates after that request and a flag
// that is set when any sum clipped. One request is taken per clock cycle while
// responses are accepted; it passes from the request register to the result
// register. The rate is set by the estimate update: request register, one layer
// of four multipliers with saturating adders, and the estimate register that
// feeds the next request. A full response register stalls the request register,
// so back-pressure reaches req_ready in the same cycle. The user must write the
// registers over the APB port only while no transaction is in flight; not enforced.

module servo_state_observer
   import sso_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

`include "servo_state_observer_assert.svh"

   cfg_type         cfg;
   rsp_payload_type next_rsp;

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_item_ff;
   est_type         est_ff, est_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   logic            advance;
   logic            req_accept;

   sso_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sso_datapath u_datapath (
      .item   (in_item_ff),
      .est    (est_ff),
      .cfg    (cfg),
      .result (next_rsp)
   );

   // request moves into the estimate/result stage when the result slot frees up
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      est_in       = est_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in       = 1'b1;
         est_in.position    = next_rsp.position_estimate;
         est_in.velocity    = next_rsp.velocity_estimate;
         est_in.disturbance = next_rsp.disturbance_estimate;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         est_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         est_ff       <= est_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         rsp_data_ff <= next_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   `SSO_ASSERT_NEXT(a_state_holds_when_idle, clock, reset, !advance, $stable(est_ff))
   `SSO_ASSERT_NEXT(a_rsp_matches_state, clock, reset, advance,
      rsp_valid_ff && (rsp_data_ff.position_estimate == est_ff.position)
      && (rsp_data_ff.velocity_estimate == est_ff.velocity))
   `SSO_ASSERT_NEXT(a_load_sets_state, clock, reset, advance && (in_item_ff.req_type == REQ_LOAD),
      !rsp_data_ff.saturated && (est_ff.disturbance == $past(in_item_ff.init_disturbance)))
   `SSO_ASSERT_SAME(a_empty_stage_ready, clock, reset, !in_valid_ff, req_ready)

endmodule
